FILE: src/cmc_pkg.sv
`default_nettype none

package cmc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned CentW  = 7;

  localparam logic [YearW-1:0]  YearMin   = 14'd1000;
  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [MonthW-1:0] MonthLast = 4'd12;
  localparam logic [HourW-1:0]  HourLast  = 5'd23;
  localparam logic [MinW-1:0]   MinLast   = 6'd59;
  localparam logic [CentW-1:0]  YremLast  = 7'd99;

  // Reciprocals for constant division: y / 100 = (y * 5243) >> 19 for y < 16384,
  // s / 7 = (s * 18725) >> 17 for s < 16384.
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam logic [14:0] Recip7        = 15'd18725;
  localparam int unsigned Recip7Shift   = 17;

  // Command queue between front and back; depth of at least two.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    KindTick = 1'b0,
    KindLoad = 1'b1
  } kind_e;

  // Date and time, with the year also kept split as century and year in century.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [CentW-1:0]  cent;
    logic [CentW-1:0]  yrem;
  } date_t;

  localparam date_t DateReset = '{
    year:   14'd2000,
    month:  4'd1,
    day:    5'd1,
    hour:   5'd0,
    minute: 6'd0,
    cent:   7'd20,
    yrem:   7'd0
  };

  typedef struct packed {
    logic  is_load;
    logic  load_ok;
    date_t date;
  } cmd_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [WdayW-1:0]  weekday;
    logic              error;
  } res_t;

  function automatic logic leap_of(input logic [1:0] year_lo, input logic [1:0] cent_lo,
                                   input logic [CentW-1:0] yrem);
    leap_of = (year_lo == 2'd0) && ((yrem != '0) || (cent_lo == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      default: month_len = 5'd0;
    endcase
  endfunction

  function automatic logic [WdayW-1:0] month_off(input logic [MonthW-1:0] m);
    case (m)
      4'd2:    month_off = 3'd3;
      4'd3:    month_off = 3'd2;
      4'd4:    month_off = 3'd5;
      4'd6:    month_off = 3'd3;
      4'd7:    month_off = 3'd5;
      4'd8:    month_off = 3'd1;
      4'd9:    month_off = 3'd4;
      4'd10:   month_off = 3'd6;
      4'd11:   month_off = 3'd2;
      4'd12:   month_off = 3'd4;
      default: month_off = 3'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: src/calendar_minute_counter_core.sv
// Calendar minute counter: Gregorian date and time with minute resolution.
//
// Input channel (push / full): one item per accepted push. kind_i low is a
// tick that advances the clock one minute; kind_i high is a load of the
// load_* fields, taken only when the date and time are valid and the year is
// 1000..9999. A rejected load, or a tick past 9999-12-31 23:59, leaves the
// clock unchanged and raises error_o on that item's result.
// Result channel (empty / pop): one result per item, in order: the date and
// time after the item, its weekday (0 Sunday .. 6 Saturday) and error_o.
// Path: a result shows once its item has passed the front register, command
// queue, update stage, weekday sum stage and output register.
// Throughput: one item per cycle while results are popped; the calendar update
// stage handles one command a cycle and each later stage one result a cycle.
// When pop is held low, results back up through the pipeline and the
// two-entry command queue, then full rises; nothing is lost or repeated.
// Reset: the clock reads 2000-01-01 00:00 and both channels are empty.
`default_nettype none

module calendar_minute_counter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind_i,
  input  logic [cmc_pkg::YearW-1:0]   load_year_i,
  input  logic [cmc_pkg::MonthW-1:0]  load_month_i,
  input  logic [cmc_pkg::DayW-1:0]    load_day_i,
  input  logic [cmc_pkg::HourW-1:0]   load_hour_i,
  input  logic [cmc_pkg::MinW-1:0]    load_minute_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [cmc_pkg::YearW-1:0]   cur_year_o,
  output logic [cmc_pkg::MonthW-1:0]  cur_month_o,
  output logic [cmc_pkg::DayW-1:0]    cur_day_o,
  output logic [cmc_pkg::HourW-1:0]   cur_hour_o,
  output logic [cmc_pkg::MinW-1:0]    cur_minute_o,
  output logic [cmc_pkg::WdayW-1:0]   weekday_o,
  output logic                        error_o
);
  import cmc_pkg::*;

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic res_valid;
  res_t res;

  // Front: register and classify items, check loads.
  cmc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .load_year_i   (load_year_i),
    .load_month_i  (load_month_i),
    .load_day_i    (load_day_i),
    .load_hour_i   (load_hour_i),
    .load_minute_i (load_minute_i),
    .cmd_valid_o   (fr_valid),
    .cmd_o         (fr_cmd),
    .cmd_ready_i   (fr_ready)
  );

  // Short queue that decouples the front from the calendar back end.
  cmc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cmd)
  );

  // Back: advance or load the calendar, compute the weekday, hold the result.
  cmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (res_valid),
    .res_ready_i (pop),
    .res_o       (res)
  );

  assign empty        = !res_valid;
  assign cur_year_o   = res.year;
  assign cur_month_o  = res.month;
  assign cur_day_o    = res.day;
  assign cur_hour_o   = res.hour;
  assign cur_minute_o = res.minute;
  assign weekday_o    = res.weekday;
  assign error_o      = res.error;

  // A shown result always carries a valid time of day and weekday.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cur_minute_o <= MinLast) && (cur_hour_o <= HourLast) &&
               (weekday_o < 3'd7))
    else $error("result carries time or weekday out of range");

  // A shown result always carries a month of 1..12, a nonzero day and a year of 1000..9999.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cur_month_o != '0) && (cur_month_o <= MonthLast) &&
               (cur_day_o != '0) && (cur_year_o >= YearMin) && (cur_year_o <= YearMax))
    else $error("result carries a date out of range");

  // The front only stalls while the queue is full.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> fr_valid && !fr_ready)
    else $error("full raised while the command queue has room");

endmodule

`default_nettype wire

FILE: src/cmc_front.sv
`default_nettype none

module cmc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        kind_i,
  input  logic [cmc_pkg::YearW-1:0]   load_year_i,
  input  logic [cmc_pkg::MonthW-1:0]  load_month_i,
  input  logic [cmc_pkg::DayW-1:0]    load_day_i,
  input  logic [cmc_pkg::HourW-1:0]   load_hour_i,
  input  logic [cmc_pkg::MinW-1:0]    load_minute_i,
  output logic                        cmd_valid_o,
  output cmc_pkg::cmd_t               cmd_o,
  input  logic                        cmd_ready_i
);
  import cmc_pkg::*;

  logic              take;
  logic              fr_v_q, fr_v_d;
  cmd_t              cmd_q, cmd_d;
  logic [26:0]       prod100;
  logic [7:0]        cent_full;
  logic [YearW-1:0]  yrem_full;
  logic              leap;
  logic              ok;

  // Split the load year into century and year in century.
  assign prod100   = 27'(load_year_i) * 27'(Recip100);
  assign cent_full = prod100[Recip100Shift +: 8];
  assign yrem_full = load_year_i - 14'({6'd0, cent_full} * 14'd100);
  assign leap      = leap_of(load_year_i[1:0], cent_full[1:0], yrem_full[CentW-1:0]);

  assign ok = (load_year_i >= YearMin) && (load_year_i <= YearMax) &&
              (load_month_i != '0) && (load_month_i <= MonthLast) &&
              (load_day_i != '0) && (load_day_i <= month_len(load_month_i, leap)) &&
              (load_hour_i <= HourLast) && (load_minute_i <= MinLast);

  always_comb begin
    cmd_d.is_load     = (kind_e'(kind_i) == KindLoad);
    cmd_d.load_ok     = ok;
    cmd_d.date.year   = load_year_i;
    cmd_d.date.month  = load_month_i;
    cmd_d.date.day    = load_day_i;
    cmd_d.date.hour   = load_hour_i;
    cmd_d.date.minute = load_minute_i;
    cmd_d.date.cent   = cent_full[CentW-1:0];
    cmd_d.date.yrem   = yrem_full[CentW-1:0];
  end

  assign full_o      = fr_v_q && !cmd_ready_i;
  assign take        = push_i && !full_o;
  assign fr_v_d      = take || (fr_v_q && !cmd_ready_i);
  assign cmd_valid_o = fr_v_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= fr_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cmc_fifo.sv
`default_nettype none

module cmc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  cmc_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output cmc_pkg::cmd_t rd_data_o
);
  import cmc_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             wr_en, rd_en;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/cmc_back.sv
`default_nettype none

module cmc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmc_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output cmc_pkg::res_t res_o
);
  import cmc_pkg::*;

  // Calendar state
  date_t st_q, st_d;

  // Stage 1: date after the item
  logic  s1_v_q;
  date_t s1_date_q;
  logic  s1_err_q;

  // Stage 2: weekday sum before reduction mod 7
  logic             s2_v_q;
  date_t            s2_date_q;
  logic             s2_err_q;
  logic [YearW-1:0] s2_sum_q;

  // Output register
  logic  out_v_q;
  res_t  out_q;

  logic  out_rdy, s2_rdy, s1_rdy, upd;
  date_t nxt;
  logic  nxt_err, leap;

  assign out_rdy     = !out_v_q || res_ready_i;
  assign s2_rdy      = !s2_v_q || out_rdy;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign cmd_ready_o = s1_rdy;
  assign upd         = cmd_valid_i && s1_rdy;

  assign leap = leap_of(st_q.year[1:0], st_q.cent[1:0], st_q.yrem);

  always_comb begin
    nxt     = st_q;
    nxt_err = 1'b0;
    if (cmd_i.is_load) begin
      if (cmd_i.load_ok) begin
        nxt = cmd_i.date;
      end else begin
        nxt_err = 1'b1;
      end
    end else if (st_q.minute != MinLast) begin
      nxt.minute = st_q.minute + 1'b1;
    end else if (st_q.hour != HourLast) begin
      nxt.minute = '0;
      nxt.hour   = st_q.hour + 1'b1;
    end else if (st_q.day < month_len(st_q.month, leap)) begin
      nxt.minute = '0;
      nxt.hour   = '0;
      nxt.day    = st_q.day + 1'b1;
    end else if (st_q.month != MonthLast) begin
      nxt.minute = '0;
      nxt.hour   = '0;
      nxt.day    = DayW'(1);
      nxt.month  = st_q.month + 1'b1;
    end else if (st_q.year != YearMax) begin
      nxt.minute = '0;
      nxt.hour   = '0;
      nxt.day    = DayW'(1);
      nxt.month  = MonthW'(1);
      nxt.year   = st_q.year + 1'b1;
      if (st_q.yrem == YremLast) begin
        nxt.yrem = '0;
        nxt.cent = st_q.cent + 1'b1;
      end else begin
        nxt.yrem = st_q.yrem + 1'b1;
      end
    end else begin
      nxt_err = 1'b1;
    end
  end

  assign st_d = upd ? nxt : st_q;

  // Weekday terms: January and February count against the previous year.
  logic             jf;
  logic [CentW-1:0] cent_a;
  logic [YearW-1:0] yy;
  logic [YearW:0]   sum;

  assign jf     = (s1_date_q.month < MonthW'(3));
  assign cent_a = s1_date_q.cent - CentW'(jf && (s1_date_q.yrem == '0));
  assign yy     = s1_date_q.year - YearW'(jf);
  assign sum    = {1'b0, yy} + {3'b0, yy[YearW-1:2]} - {8'd0, cent_a}
                + {10'd0, cent_a[CentW-1:2]} + {12'd0, month_off(s1_date_q.month)}
                + {10'd0, s1_date_q.day};

  // Reduce the sum mod 7.
  logic [28:0]      prod7;
  logic [11:0]      q7;
  logic [YearW-1:0] r7;

  assign prod7 = 29'(s2_sum_q) * 29'(Recip7);
  assign q7    = prod7[Recip7Shift +: 12];
  assign r7    = s2_sum_q - 14'({2'd0, q7} * 14'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= DateReset;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (s1_rdy) begin
        s1_v_q <= upd;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      s1_date_q <= nxt;
      s1_err_q  <= nxt_err;
    end
    if (s2_rdy && s1_v_q) begin
      s2_date_q <= s1_date_q;
      s2_err_q  <= s1_err_q;
      s2_sum_q  <= sum[YearW-1:0];
    end
    if (out_rdy && s2_v_q) begin
      out_q.year    <= s2_date_q.year;
      out_q.month   <= s2_date_q.month;
      out_q.day     <= s2_date_q.day;
      out_q.hour    <= s2_date_q.hour;
      out_q.minute  <= s2_date_q.minute;
      out_q.weekday <= r7[WdayW-1:0];
      out_q.error   <= s2_err_q;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire
